// File: design/bpes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpes_pkg
// Shared types, codes and the pair energy function for the bracket pair
// energy scanner.
// ----------------------------------------------------------------------------
package bpes_pkg;

  // Item field widths
  localparam int SYMBOL_W   = 8;
  localparam int BASE_W     = 3;
  localparam int POSITION_W = 10;
  localparam int ENERGY_W   = 2;
  localparam int TOTAL_W    = 11;
  localparam int STATUS_W   = 3;

  // One stack entry: {position, base}
  localparam int ENTRY_W = POSITION_W + BASE_W;

  // Structure characters
  localparam logic [SYMBOL_W-1:0] SYM_OPEN  = 8'h28;
  localparam logic [SYMBOL_W-1:0] SYM_CLOSE = 8'h29;

  // Base codes
  localparam logic [BASE_W-1:0] BASE_A = 3'd1;
  localparam logic [BASE_W-1:0] BASE_C = 3'd2;
  localparam logic [BASE_W-1:0] BASE_G = 3'd3;
  localparam logic [BASE_W-1:0] BASE_U = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_OPEN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

  // Pair energies
  localparam logic [ENERGY_W-1:0] E_GC   = 2'd3;
  localparam logic [ENERGY_W-1:0] E_AU   = 2'd2;
  localparam logic [ENERGY_W-1:0] E_GU   = 2'd1;
  localparam logic [ENERGY_W-1:0] E_NONE = 2'd0;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [ENTRY_W-1:0] entry_t;

  // Shift control handed along the cell row
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  // Energy of a base pair, order independent
  function automatic logic [ENERGY_W-1:0] pair_value(input logic [BASE_W-1:0] a,
                                                     input logic [BASE_W-1:0] b);
    logic [ENERGY_W-1:0] e;
    e = E_NONE;
    if ((a == BASE_G && b == BASE_C) || (a == BASE_C && b == BASE_G)) begin
      e = E_GC;
    end else if ((a == BASE_A && b == BASE_U) || (a == BASE_U && b == BASE_A)) begin
      e = E_AU;
    end else if ((a == BASE_G && b == BASE_U) || (a == BASE_U && b == BASE_G)) begin
      e = E_GU;
    end
    return e;
  endfunction

endpackage

// File: design/bpes_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpes_cell
// One slot of the shift stack: takes the entry above on push, the entry
// below on pop, and holds otherwise.
// ----------------------------------------------------------------------------
module bpes_cell
  import bpes_pkg::*;
(
  input  logic      clk,
  input  stack_op_t op,
  input  entry_t    upper,
  input  entry_t    lower,
  output entry_t    data
);

  // Shift toward the bottom on push, toward the top on pop
  always_ff @(posedge clk) begin
    if (op.push) begin
      data <= upper;
    end else if (op.pop) begin
      data <= lower;
    end
  end

endmodule

// File: design/bpes_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpes_stack
// Row of DEPTH cells forming a shift stack; cell 0 always holds the top
// entry, so a push or pop touches only neighbors.
// ----------------------------------------------------------------------------
module bpes_stack
  import bpes_pkg::*;
#(
  parameter int DEPTH = 512
) (
  input  logic      clk,
  input  stack_op_t op,
  input  entry_t    push_data,
  output entry_t    top
);

  entry_t cells [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      entry_t upper;
      entry_t lower;

      // Feed the new entry into the head, recirculate at the tail
      if (i == 0) begin : g_head
        assign upper = push_data;
      end else begin : g_body
        assign upper = cells[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign lower = cells[i];
      end else begin : g_mid
        assign lower = cells[i+1];
      end

      bpes_cell u_cell (
        .clk   (clk),
        .op    (op),
        .upper (upper),
        .lower (lower),
        .data  (cells[i])
      );
    end
  endgenerate

  assign top = cells[0];

endmodule

// File: design/bracket_pair_energy_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_pair_energy_scan
// Dot-bracket scanner: matches brackets on a shift stack of cells, reports
// pairs, running pair energy and a sticky error status per structure.
// ----------------------------------------------------------------------------
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle unless out_stall blocks a held result; the stack
// top always sits in cell 0, so a push or pop completes in the cycle of acceptance.
// Reset (rst, synchronous): clears counters, energy sum, status and out_valid;
// stack cells are not cleared and are only read below the fill count.
module bracket_pair_energy_scan
  import bpes_pkg::*;
#(
  parameter int MAX_LENGTH  = 1024,
  parameter int STACK_DEPTH = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SYMBOL_W-1:0]   symbol,
  input  logic [BASE_W-1:0]     base_code,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [POSITION_W-1:0] position,
  output logic                  paired,
  output logic [POSITION_W-1:0] partner,
  output logic [ENERGY_W-1:0]   pair_energy,
  output logic [TOTAL_W-1:0]    energy_total,
  output logic [STATUS_W-1:0]   status,
  output logic                  end_of_structure
);

  localparam int PW = $clog2(MAX_LENGTH + 1);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] LEN_LIMIT = PW'(MAX_LENGTH);
  localparam logic [CW-1:0] DEPTH_LIMIT = CW'(STACK_DEPTH);

  logic [PW-1:0]       pos_count;
  logic [CW-1:0]       stack_count;
  logic [TOTAL_W-1:0]  energy_sum;
  logic [STATUS_W-1:0] error_status;

  logic [PW-1:0]       pos_count_next;
  logic [CW-1:0]       stack_count_next;
  logic [TOTAL_W-1:0]  energy_sum_next;
  logic [STATUS_W-1:0] error_status_next;

  logic                accept;
  logic                too_long;
  logic                is_open;
  logic                is_close;
  logic                full;
  logic                empty;
  stack_op_t           op;
  entry_t              push_data;
  entry_t              top;
  logic [ENERGY_W-1:0] energy;
  logic [TOTAL_W:0]    sum_wide;
  logic [TOTAL_W-1:0]  sum_new;
  logic [STATUS_W-1:0] item_err;
  logic [STATUS_W-1:0] err_step;
  logic [STATUS_W-1:0] err_final;
  logic [PW-1:0]       pos_report;

  // Take an item unless a held result is blocked
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Decode the item
  always_comb begin
    too_long  = (pos_count >= LEN_LIMIT);
    is_open   = (symbol == SYM_OPEN);
    is_close  = (symbol == SYM_CLOSE);
    full      = (stack_count == DEPTH_LIMIT);
    empty     = (stack_count == '0);
    op.push   = accept && !too_long && is_open && !full;
    op.pop    = accept && !too_long && is_close && !empty;
    push_data = {POSITION_W'(pos_count), base_code};
  end

  bpes_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .op        (op),
    .push_data (push_data),
    .top       (top)
  );

  // Score the pair and fold the sticky status
  always_comb begin
    energy   = op.pop ? pair_value(top[BASE_W-1:0], base_code) : E_NONE;
    sum_wide = {1'b0, energy_sum} + {{(TOTAL_W + 1 - ENERGY_W){1'b0}}, energy};
    sum_new  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

    stack_count_next = stack_count;
    if (op.push) begin
      stack_count_next = stack_count + CW'(1);
    end else if (op.pop) begin
      stack_count_next = stack_count - CW'(1);
    end

    item_err = ST_OK;
    if (too_long) begin
      item_err = ST_TOO_LONG;
    end else if (is_open && full) begin
      item_err = ST_OVERFLOW;
    end else if (is_close && empty) begin
      item_err = ST_NO_OPEN;
    end
    err_step  = (error_status != ST_OK) ? error_status : item_err;
    err_final = err_step;
    if (last && (stack_count_next != '0) && (err_step == ST_OK)) begin
      err_final = ST_UNCLOSED;
    end

    pos_report = too_long ? LEN_LIMIT : pos_count;
    pos_count_next = too_long ? pos_count : pos_count + PW'(1);
    energy_sum_next = sum_new;
    error_status_next = err_final;

    // Start a new structure after the final position
    if (last) begin
      pos_count_next    = '0;
      stack_count_next  = '0;
      energy_sum_next   = '0;
      error_status_next = ST_OK;
    end
  end

  // Advance the structure state on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count    <= '0;
      stack_count  <= '0;
      energy_sum   <= '0;
      error_status <= ST_OK;
    end else if (accept) begin
      pos_count    <= pos_count_next;
      stack_count  <= stack_count_next;
      energy_sum   <= energy_sum_next;
      error_status <= error_status_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      position         <= POSITION_W'(pos_report);
      paired           <= op.pop;
      partner          <= op.pop ? top[ENTRY_W-1:BASE_W] : '0;
      pair_energy      <= energy;
      energy_total     <= sum_new;
      status           <= err_final;
      end_of_structure <= last;
    end
  end

endmodule
